/* hw/rtl/ephr_pkg.sv */
// Shared types, sizes and constants of the high-pass event reconstruction block.
package ephr_pkg;

    localparam int unsigned LP_IMG_W    = 512;
    localparam int unsigned LP_IMG_H    = 512;
    localparam int unsigned LP_LUT_BITS = 10;

    localparam int unsigned LP_NPIX     = LP_IMG_W * LP_IMG_H;
    localparam int unsigned LP_ADDR_W   = $clog2(LP_NPIX);
    localparam int unsigned LP_LUT_SIZE = 1 << LP_LUT_BITS;
    localparam int unsigned LP_CLR_CNT  = (LP_NPIX > LP_LUT_SIZE) ? LP_NPIX : LP_LUT_SIZE;
    localparam int unsigned LP_CNT_W    = $clog2(LP_CLR_CNT);

    localparam int unsigned LP_VAL_W    = 32;
    localparam int unsigned LP_TIME_W   = 32;
    localparam int unsigned LP_RATE_W   = 10;
    localparam int unsigned LP_STEP_W   = 20;
    localparam int unsigned LP_FACT_W   = 17;
    localparam int unsigned LP_ACCQ_W   = 33;

    // rate * dt
    localparam int unsigned LP_PROD_W   = LP_RATE_W + LP_TIME_W;
    // index = (prod * 2^bits + 8e6) / 16e6, with 16e6 = 2^10 * 15625
    localparam int unsigned LP_DIV_HALF  = 8000000;
    localparam int unsigned LP_DIV_FULL  = 16000000;
    localparam int unsigned LP_DIV_SHIFT = 10;
    localparam int unsigned LP_DIV_ODD   = 15625;
    localparam int unsigned LP_PROD_LIM  = LP_DIV_FULL - LP_DIV_HALF / LP_LUT_SIZE;
    localparam int unsigned LP_LIM_W     = 24;
    localparam int unsigned LP_N_W       = LP_LUT_BITS + LP_LIM_W;
    localparam int unsigned LP_N1_W      = LP_N_W - LP_DIV_SHIFT;
    localparam int unsigned LP_RECIP_SH  = LP_N1_W + 14;
    localparam int unsigned LP_RECIP_W   = LP_N1_W + 1;
    localparam int unsigned LP_QP_W      = LP_N1_W + LP_RECIP_W;
    localparam logic [LP_RECIP_W-1:0] LP_RECIP =
        LP_RECIP_W'(((64'd1 << LP_RECIP_SH) + 64'(LP_DIV_ODD - 1)) / 64'(LP_DIV_ODD));

    localparam int unsigned LP_SCL_W = LP_VAL_W + LP_FACT_W;
    localparam int unsigned LP_MAGR_W = LP_SCL_W + 1 - 16;
    localparam int unsigned LP_SUM_W = LP_MAGR_W + 2;
    localparam logic signed [LP_SUM_W-1:0] LP_SAT_MAX = LP_SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [LP_SUM_W-1:0] LP_SAT_MIN = LP_SUM_W'(-64'sh8000_0000);

    localparam logic [0:0] LP_CFG_RATE = 1'b0;
    localparam logic [0:0] LP_CFG_STEP = 1'b1;
    localparam logic [LP_RATE_W-1:0] LP_RATE_RST = LP_RATE_W'(1);
    localparam logic [LP_STEP_W-1:0] LP_STEP_RST = LP_STEP_W'(6554);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    // exp(-16 / 2^bits) in Q0.32 from a truncated alternating series
    function automatic logic [31:0] f_estep();
        longint unsigned st;
        longint unsigned tm;
        longint          sum;
        st  = 64'd1 << (36 - LP_LUT_BITS);
        tm  = 64'd1 << 32;
        sum = longint'(64'd1 << 32);
        tm = ((tm * st) >> 32) / 64'd1;  sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd2;  sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd3;  sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd4;  sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd5;  sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd6;  sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd7;  sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd8;  sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd9;  sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd10; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd11; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd12; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd13; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd14; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd15; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd16; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd17; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd18; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd19; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd20; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd21; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd22; sum = sum + longint'(tm);
        tm = ((tm * st) >> 32) / 64'd23; sum = sum - longint'(tm);
        tm = ((tm * st) >> 32) / 64'd24; sum = sum + longint'(tm);
        return (sum < 0) ? 32'd0 : 32'(sum);
    endfunction

    localparam logic [31:0] LP_ESTEP = f_estep();

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_SWEEP,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        logic [LP_RATE_W-1:0] decay_rate;
        logic [LP_STEP_W-1:0] contrast_step;
    } t_cfg;

    typedef struct packed {
        logic                 clr;
        logic [LP_CNT_W-1:0]  clr_idx;
        logic                 load;
        logic                 issue;
        logic                 sweep;
        logic [LP_ADDR_W-1:0] sweep_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_stat;

    typedef struct packed {
        logic load;
        logic has_value;
        logic sweep_done;
    } t_out_cmd;

endpackage

/* hw/rtl/event_pixel_highpass_reconstruct.sv */
// Pixel event: read from both stores, updated through the pipeline and written back; the next
// input beat is taken only once the result has been loaded into the output register.
// Global decay: one pixel per cycle through the datapath. Rate is set by the single read
// port of each pixel store, shared by all pixels of a sweep. After reset a clearing pass
// zeroes both stores and builds the decay LUT; input is not ready until it ends. Config
// writes are always taken. The output register holds a result while the next item is accepted.
module event_pixel_highpass_reconstruct (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [0:0]                            i_cfg_index,
    input  logic [ephr_pkg::LP_STEP_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic [8:0]                            i_pixel_x,
    input  logic [8:0]                            i_pixel_y,
    input  logic                                  i_polarity,
    input  logic [ephr_pkg::LP_TIME_W-1:0]        i_event_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ephr_pkg::LP_VAL_W-1:0]  o_pixel_value,
    output logic                                  o_sweep_done
);

    ephr_pkg::t_cfg                         r_cfg;
    ephr_pkg::t_dp_cmd                      w_cmd;
    ephr_pkg::t_dp_stat                     w_stat;
    ephr_pkg::t_out_cmd                     w_out;
    logic signed [ephr_pkg::LP_VAL_W-1:0]   w_result;
    logic                                   w_in_range;
    logic                                   w_out_free;
    logic                                   r_out_vld;
    logic signed [ephr_pkg::LP_VAL_W-1:0]   r_out_value;
    logic                                   r_out_sweep;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_rate    <= ephr_pkg::LP_RATE_RST;
            r_cfg.contrast_step <= ephr_pkg::LP_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ephr_pkg::LP_CFG_RATE: r_cfg.decay_rate    <= i_cfg_data[ephr_pkg::LP_RATE_W-1:0];
                ephr_pkg::LP_CFG_STEP: r_cfg.contrast_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_in_range = (32'(i_pixel_x) < ephr_pkg::LP_IMG_W) &&
                        (32'(i_pixel_y) < ephr_pkg::LP_IMG_H);
    assign w_out_free = !r_out_vld || i_out_ready;

    ephr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_in_range (w_in_range),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .o_out      (w_out)
    );

    ephr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (w_cmd),
        .i_command    (i_command),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_polarity   (i_polarity),
        .i_event_time (i_event_time),
        .o_stat       (w_stat),
        .o_result     (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out.load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out.load) begin
            r_out_value <= w_out.has_value ? w_result : '0;
            r_out_sweep <= w_out.sweep_done;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_value = r_out_value;
    assign o_sweep_done  = r_out_sweep;

endmodule

/* hw/rtl/ephr_ram.sv */
// Generic simple dual-port RAM with registered read.
module ephr_ram #(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned DEPTH  = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]                       i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]                       o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/ephr_ctrl.sv */
// Controller: reset clearing pass, item sequencing and result handoff.
module ephr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    input  logic                i_in_range,
    input  logic                i_out_free,
    input  ephr_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output ephr_pkg::t_dp_cmd   o_cmd,
    output ephr_pkg::t_out_cmd  o_out
);

    ephr_pkg::t_state                r_state;
    ephr_pkg::t_state                n_state;
    ephr_pkg::t_kind                 r_kind;
    ephr_pkg::t_kind                 n_kind;
    logic [ephr_pkg::LP_CNT_W-1:0]   r_cnt;
    logic [ephr_pkg::LP_CNT_W-1:0]   n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ephr_pkg::ST_CLEAR;
            r_kind  <= ephr_pkg::KIND_SKIP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_kind           = r_kind;
        n_cnt            = r_cnt;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.clr_idx    = r_cnt;
        o_cmd.sweep_addr = r_cnt[ephr_pkg::LP_ADDR_W-1:0];
        o_out            = '0;
        case (r_state)
            ephr_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_cnt == ephr_pkg::LP_CNT_W'(ephr_pkg::LP_CLR_CNT - 1)) begin
                    n_cnt   = '0;
                    n_state = ephr_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ephr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (i_command == ephr_pkg::CMD_SWEEP) begin
                        n_kind  = ephr_pkg::KIND_SWEEP;
                        n_state = ephr_pkg::ST_SWEEP;
                    end else if (i_in_range) begin
                        n_kind  = ephr_pkg::KIND_PIXEL;
                        n_state = ephr_pkg::ST_ISSUE;
                    end else begin
                        n_kind  = ephr_pkg::KIND_SKIP;
                        n_state = ephr_pkg::ST_DONE;
                    end
                end
            end
            ephr_pkg::ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = ephr_pkg::ST_DRAIN;
            end
            ephr_pkg::ST_SWEEP: begin
                // one pixel enters the datapath per cycle
                o_cmd.issue = 1'b1;
                o_cmd.sweep = 1'b1;
                if (r_cnt == ephr_pkg::LP_CNT_W'(ephr_pkg::LP_NPIX - 1)) begin
                    n_cnt   = '0;
                    n_state = ephr_pkg::ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ephr_pkg::ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ephr_pkg::ST_DONE;
                end
            end
            ephr_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_out.load       = 1'b1;
                    o_out.has_value  = (r_kind == ephr_pkg::KIND_PIXEL);
                    o_out.sweep_done = (r_kind == ephr_pkg::KIND_SWEEP);
                    n_state          = ephr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ephr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/ephr_dp.sv */
// Datapath: pixel stores, decay LUT and the pipelined decay/update arithmetic.
module ephr_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ephr_pkg::t_cfg                        i_cfg,
    input  ephr_pkg::t_dp_cmd                     i_cmd,
    input  logic                                  i_command,
    input  logic [8:0]                            i_pixel_x,
    input  logic [8:0]                            i_pixel_y,
    input  logic                                  i_polarity,
    input  logic [ephr_pkg::LP_TIME_W-1:0]        i_event_time,
    output ephr_pkg::t_dp_stat                    o_stat,
    output logic signed [ephr_pkg::LP_VAL_W-1:0]  o_result
);

    localparam int unsigned AW = ephr_pkg::LP_ADDR_W;
    localparam int unsigned VW = ephr_pkg::LP_VAL_W;
    localparam int unsigned TW = ephr_pkg::LP_TIME_W;
    localparam int unsigned SW = ephr_pkg::LP_SUM_W;

    // item registers, stable while the item is in flight
    logic [TW-1:0] r_t;
    logic          r_pol;
    logic          r_evt;
    logic [AW-1:0] r_addr;

    // stage registers
    logic                              r_s1_vld;
    logic [AW-1:0]                     r_s1_addr;
    logic                              r_s2_vld;
    logic [AW-1:0]                     r_s2_addr;
    logic signed [VW-1:0]              r_s2_val;
    logic [ephr_pkg::LP_PROD_W-1:0]    r_s2_prod;
    logic                              r_s3_vld;
    logic [AW-1:0]                     r_s3_addr;
    logic signed [VW-1:0]              r_s3_val;
    logic                              r_s3_over;
    logic [ephr_pkg::LP_N1_W-1:0]      r_s3_n1;
    logic                              r_s4_vld;
    logic [AW-1:0]                     r_s4_addr;
    logic signed [VW-1:0]              r_s4_val;
    logic                              r_s4_over;
    logic [ephr_pkg::LP_QP_W-1:0]      r_s4_qp;
    logic                              r_s5_vld;
    logic [AW-1:0]                     r_s5_addr;
    logic signed [VW-1:0]              r_s5_val;
    logic                              r_s5_over;
    logic                              r_s6_vld;
    logic [AW-1:0]                     r_s6_addr;
    logic                              r_s6_neg;
    logic [ephr_pkg::LP_SCL_W-1:0]     r_s6_scl;
    logic signed [VW-1:0]              r_result;

    // LUT fill accumulator, Q1.32 with one integer bit
    logic [ephr_pkg::LP_ACCQ_W-1:0]    r_acc;
    logic [ephr_pkg::LP_ACCQ_W-1:0]    n_acc;
    logic [2*ephr_pkg::LP_ACCQ_W-2:0]  w_acc_prod;
    logic [ephr_pkg::LP_ACCQ_W-1:0]    w_acc_rnd;

    logic [AW-1:0]                     w_rd_addr;
    logic                              w_px_we;
    logic [AW-1:0]                     w_px_waddr;
    logic [VW-1:0]                     w_log_wdata;
    logic [TW-1:0]                     w_time_wdata;
    logic [VW-1:0]                     w_log_q;
    logic [TW-1:0]                     w_time_q;
    logic                              w_lut_we;
    logic [ephr_pkg::LP_FACT_W-1:0]    w_lut_wdata;
    logic [ephr_pkg::LP_FACT_W-1:0]    w_lut_q;
    logic [ephr_pkg::LP_LUT_BITS-1:0]  w_lut_idx;

    logic [TW-1:0]                     w_dt;
    logic [ephr_pkg::LP_PROD_W-1:0]    w_prod;
    logic                              w_over;
    logic [ephr_pkg::LP_N_W-1:0]       w_num;
    logic [ephr_pkg::LP_QP_W-1:0]      w_qp;
    logic [ephr_pkg::LP_FACT_W-1:0]    w_fact;
    logic                              w_neg;
    logic [VW-1:0]                     w_mag;
    logic [ephr_pkg::LP_SCL_W-1:0]     w_scl;
    logic [ephr_pkg::LP_SCL_W:0]       w_rnd;
    logic [ephr_pkg::LP_MAGR_W-1:0]    w_mag_r;
    logic signed [SW-1:0]              w_sv;
    logic signed [SW-1:0]              w_stp;
    logic signed [SW-1:0]              w_sum;
    logic signed [VW-1:0]              w_sat;

    // ---------------- item capture ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t    <= i_event_time;
            r_pol  <= i_polarity;
            r_evt  <= (i_command == ephr_pkg::CMD_PIXEL);
            r_addr <= AW'(32'(i_pixel_y) * ephr_pkg::LP_IMG_W + 32'(i_pixel_x));
        end
    end

    // ---------------- decay LUT fill ----------------
    assign w_acc_prod = (2*ephr_pkg::LP_ACCQ_W-1)'(r_acc) *
                        (2*ephr_pkg::LP_ACCQ_W-1)'(ephr_pkg::LP_ESTEP) +
                        ((2*ephr_pkg::LP_ACCQ_W-1)'(1) << 31);
    assign n_acc      = w_acc_prod[2*ephr_pkg::LP_ACCQ_W-2:32];
    assign w_acc_rnd  = r_acc + ephr_pkg::LP_ACCQ_W'(16'h8000);
    assign w_lut_wdata = w_acc_rnd[ephr_pkg::LP_ACCQ_W-1:16];
    assign w_lut_we   = i_cmd.clr && (32'(i_cmd.clr_idx) < ephr_pkg::LP_LUT_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= ephr_pkg::LP_ACCQ_W'(64'd1 << 32);
        end else if (i_cmd.clr) begin
            r_acc <= n_acc;
        end
    end

    // ---------------- stores ----------------
    assign w_rd_addr    = i_cmd.sweep ? i_cmd.sweep_addr : r_addr;
    assign w_px_we      = (i_cmd.clr && (32'(i_cmd.clr_idx) < ephr_pkg::LP_NPIX)) || r_s6_vld;
    assign w_px_waddr   = i_cmd.clr ? i_cmd.clr_idx[AW-1:0] : r_s6_addr;
    assign w_log_wdata  = i_cmd.clr ? '0 : w_sat;
    assign w_time_wdata = i_cmd.clr ? '0 : r_t;

    ephr_ram #(
        .DATA_W (VW),
        .DEPTH  (ephr_pkg::LP_NPIX)
    ) u_log_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_px_we),
        .i_wr_addr (w_px_waddr),
        .i_wr_data (w_log_wdata),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_log_q)
    );

    ephr_ram #(
        .DATA_W (TW),
        .DEPTH  (ephr_pkg::LP_NPIX)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_px_we),
        .i_wr_addr (w_px_waddr),
        .i_wr_data (w_time_wdata),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_time_q)
    );

    ephr_ram #(
        .DATA_W (ephr_pkg::LP_FACT_W),
        .DEPTH  (ephr_pkg::LP_LUT_SIZE)
    ) u_lut_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_lut_we),
        .i_wr_addr (i_cmd.clr_idx[ephr_pkg::LP_LUT_BITS-1:0]),
        .i_wr_data (w_lut_wdata),
        .i_rd_en   (r_s4_vld),
        .i_rd_addr (w_lut_idx),
        .o_rd_data (w_lut_q)
    );

    // ---------------- arithmetic ----------------
    // backwards time counts as no elapsed time
    assign w_dt   = (r_t >= w_time_q) ? (r_t - w_time_q) : '0;
    assign w_prod = ephr_pkg::LP_PROD_W'(i_cfg.decay_rate) * ephr_pkg::LP_PROD_W'(w_dt);

    // index past the table end when prod reaches the limit
    assign w_over = (r_s2_prod >= ephr_pkg::LP_PROD_W'(ephr_pkg::LP_PROD_LIM));
    assign w_num  = (ephr_pkg::LP_N_W'(r_s2_prod[ephr_pkg::LP_LIM_W-1:0])
                     << ephr_pkg::LP_LUT_BITS) + ephr_pkg::LP_N_W'(ephr_pkg::LP_DIV_HALF);

    // divide by the odd part of 16e6 through an exact reciprocal
    assign w_qp      = ephr_pkg::LP_QP_W'(r_s3_n1) * ephr_pkg::LP_QP_W'(ephr_pkg::LP_RECIP);
    assign w_lut_idx = r_s4_qp[ephr_pkg::LP_RECIP_SH +: ephr_pkg::LP_LUT_BITS];

    assign w_fact = r_s5_over ? '0 : w_lut_q;
    assign w_neg  = r_s5_val[VW-1];
    assign w_mag  = w_neg ? (~r_s5_val + 1'b1) : r_s5_val;
    assign w_scl  = ephr_pkg::LP_SCL_W'(w_mag) * ephr_pkg::LP_SCL_W'(w_fact);

    // round half away from zero, then the signed step for pixel events and saturation
    assign w_rnd   = {1'b0, r_s6_scl} + (ephr_pkg::LP_SCL_W+1)'(16'h8000);
    assign w_mag_r = w_rnd[ephr_pkg::LP_SCL_W:16];
    assign w_sv    = r_s6_neg ? -$signed(SW'(w_mag_r)) : $signed(SW'(w_mag_r));
    assign w_stp   = $signed(SW'(i_cfg.contrast_step));

    always_comb begin
        if (!r_evt) begin
            w_sum = w_sv;
        end else if (r_pol) begin
            w_sum = w_sv - w_stp;
        end else begin
            w_sum = w_sv + w_stp;
        end
        if (w_sum > ephr_pkg::LP_SAT_MAX) begin
            w_sat = VW'(ephr_pkg::LP_SAT_MAX);
        end else if (w_sum < ephr_pkg::LP_SAT_MIN) begin
            w_sat = VW'(ephr_pkg::LP_SAT_MIN);
        end else begin
            w_sat = VW'(w_sum);
        end
    end

    // ---------------- pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= w_rd_addr;

        r_s2_addr <= r_s1_addr;
        r_s2_val  <= w_log_q;
        r_s2_prod <= w_prod;

        r_s3_addr <= r_s2_addr;
        r_s3_val  <= r_s2_val;
        r_s3_over <= w_over;
        r_s3_n1   <= w_num[ephr_pkg::LP_N_W-1:ephr_pkg::LP_DIV_SHIFT];

        r_s4_addr <= r_s3_addr;
        r_s4_val  <= r_s3_val;
        r_s4_over <= r_s3_over;
        r_s4_qp   <= w_qp;

        r_s5_addr <= r_s4_addr;
        r_s5_val  <= r_s4_val;
        r_s5_over <= r_s4_over;

        r_s6_addr <= r_s5_addr;
        r_s6_neg  <= w_neg;
        r_s6_scl  <= w_scl;

        if (r_s6_vld) begin
            r_result <= w_sat;
        end
    end

    assign o_stat.busy = r_s1_vld | r_s2_vld | r_s3_vld | r_s4_vld | r_s5_vld | r_s6_vld;
    assign o_result    = r_result;

endmodule
